/* rtl/pcm_format_normalizer_unit_macros.svh */
// ---------------------------------------------------------------------------
// PCM format normalizer assertion macros
// Concurrent assertion shorthands for the normalizer RTL.
// ---------------------------------------------------------------------------
`ifndef PCM_FORMAT_NORMALIZER_UNIT_MACROS_SVH
`define PCM_FORMAT_NORMALIZER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFN_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/pfn_pkg.sv */
// ---------------------------------------------------------------------------
// PCM format normalizer package
// Register indexes, mode codes, scale constant and the frame record type.
// ---------------------------------------------------------------------------
package pfn_pkg;

   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_EIGHT_BIT_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_CHANNELS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_RATE_MODE = 2'd2;

   // Channel and rate codes.
   localparam logic [1:0] CHANNELS_MONO   = 2'd1;
   localparam logic [1:0] CHANNELS_STEREO = 2'd2;
   localparam logic [1:0] RATE_PASS       = 2'd0;
   localparam logic [1:0] RATE_HALVE      = 2'd1;
   localparam logic [1:0] RATE_DOUBLE     = 2'd2;

   localparam logic [7:0] BYTE_SCALE = 8'd127;

   typedef struct packed {
      logic                emit;   // the item gives at least one frame
      logic                dup;    // the frame goes out twice
      logic [SAMPLE_W-1:0] left;
      logic [SAMPLE_W-1:0] right;
   } pfn_frame_type;

endpackage

/* rtl/pfn_convert.sv */
// ---------------------------------------------------------------------------
// PCM format normalizer conversion stage
// Widens the sample, pairs or duplicates channels and applies the rate rule,
// holding the pairing and decimation state between items.
// ---------------------------------------------------------------------------
module pfn_convert
   import pfn_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [SAMPLE_W-1:0] sample_word,
   input  logic                block_start,
   input  logic                eight_bit_mode,
   input  logic [1:0]          source_channels,
   input  logic [1:0]          source_rate_mode,
   output pfn_frame_type       frame
);

   logic [SAMPLE_W-1:0] held_left_ff, held_left_in;
   logic                have_left_ff, have_left_in;
   logic                frame_phase_ff, frame_phase_in;
   logic [SAMPLE_W-1:0] widened;
   logic [SAMPLE_W-1:0] scaled;
   logic                have_now;
   logic                phase_now;
   logic                pair_done;

   // A byte times 127 fits in 15 bits.
   assign scaled  = {8'd0, sample_word[7:0]} * {8'd0, BYTE_SCALE};
   assign widened = eight_bit_mode ? scaled : sample_word;

   always_comb begin
      have_now       = block_start ? 1'b0 : have_left_ff;
      phase_now      = block_start ? 1'b0 : frame_phase_ff;
      held_left_in   = held_left_ff;
      have_left_in   = have_now;
      frame_phase_in = phase_now;
      pair_done      = 1'b1;
      frame.emit     = 1'b0;
      frame.dup      = 1'b0;
      frame.left     = widened;
      frame.right    = widened;

      if (source_channels != CHANNELS_MONO) begin
         if (!have_now) begin
            held_left_in = widened;
            have_left_in = 1'b1;
            pair_done    = 1'b0;
         end else begin
            frame.left   = held_left_ff;
            have_left_in = 1'b0;
         end
      end

      if (pair_done) begin
         unique case (source_rate_mode)
            RATE_HALVE: begin
               frame.emit     = !phase_now;
               frame_phase_in = !phase_now;
            end
            RATE_DOUBLE: begin
               frame.emit = 1'b1;
               frame.dup  = 1'b1;
            end
            default: begin
               frame.emit = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_left_ff   <= '0;
         have_left_ff   <= 1'b0;
         frame_phase_ff <= 1'b0;
      end else if (advance) begin
         held_left_ff   <= held_left_in;
         have_left_ff   <= have_left_in;
         frame_phase_ff <= frame_phase_in;
      end
   end

endmodule

/* rtl/pfn_out_stage.sv */
// ---------------------------------------------------------------------------
// PCM format normalizer result register
// Holds one frame and sends it once or twice on the result channel.
// ---------------------------------------------------------------------------
module pfn_out_stage
   import pfn_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  pfn_frame_type              frame,
   output logic                       free,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_left_sample,
   output logic signed [SAMPLE_W-1:0] rsp_right_sample,
   output logic                       rsp_last_of_run
);

   logic                valid_ff;
   logic                dup_ff;
   logic [SAMPLE_W-1:0] left_ff;
   logic [SAMPLE_W-1:0] right_ff;
   logic                fire;

   assign fire = valid_ff && rsp_ready;
   // The register can take a new frame once its final copy is leaving.
   assign free = !valid_ff || (rsp_ready && !dup_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         dup_ff   <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
         dup_ff   <= frame.dup;
      end else if (fire) begin
         if (dup_ff) begin
            dup_ff <= 1'b0;
         end else begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         left_ff  <= frame.left;
         right_ff <= frame.right;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_left_sample  = left_ff;
   assign rsp_right_sample = right_ff;
   assign rsp_last_of_run  = !dup_ff;

endmodule

/* rtl/pcm_format_normalizer_unit.sv */
// ---------------------------------------------------------------------------
// PCM format normalizer
// Turns source PCM samples into 16-bit stereo frames.
// ---------------------------------------------------------------------------
// Each sample word is registered on acceptance, converted and placed in a
// result register, so a new word can be accepted every cycle while that
// register is free. In pass and halve modes the block sustains one word per
// cycle while rsp_ready is high; in double mode each frame occupies the
// result register for two transfers. The result register is the only limit
// on rate. The user must write configuration through the csr_ port only
// while no word is in flight; the block does not enforce this. Writes do
// not disturb the pairing state.
`include "pcm_format_normalizer_unit_macros.svh"

module pcm_format_normalizer_unit
   import pfn_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_write_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [SAMPLE_W-1:0]          req_sample_word,
   input  logic                         req_block_start,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [SAMPLE_W-1:0]   rsp_left_sample,
   output logic signed [SAMPLE_W-1:0]   rsp_right_sample,
   output logic                         rsp_last_of_run
);

   logic                eight_bit_ff;
   logic [1:0]          channels_ff;
   logic [1:0]          rate_ff;
   logic                a_valid_ff;
   logic [SAMPLE_W-1:0] a_sample_ff;
   logic                a_block_start_ff;
   logic                out_free;
   logic                a_advance;
   pfn_frame_type       frame;

   always_ff @(posedge clock) begin
      if (reset) begin
         eight_bit_ff <= 1'b0;
         channels_ff  <= CHANNELS_STEREO;
         rate_ff      <= RATE_PASS;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_EIGHT_BIT_MODE:   eight_bit_ff <= csr_write_data[0];
            CSR_SOURCE_CHANNELS:  channels_ff  <= csr_write_data;
            CSR_SOURCE_RATE_MODE: rate_ff      <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign a_advance = a_valid_ff && out_free;
   assign req_ready = !a_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_ready) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         a_sample_ff      <= req_sample_word;
         a_block_start_ff <= req_block_start;
      end
   end

   pfn_convert u_convert (
      .clock            (clock),
      .reset            (reset),
      .advance          (a_advance),
      .sample_word      (a_sample_ff),
      .block_start      (a_block_start_ff),
      .eight_bit_mode   (eight_bit_ff),
      .source_channels  (channels_ff),
      .source_rate_mode (rate_ff),
      .frame            (frame)
   );

   pfn_out_stage u_out (
      .clock            (clock),
      .reset            (reset),
      .load             (a_advance && frame.emit),
      .frame            (frame),
      .free             (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_left_sample  (rsp_left_sample),
      .rsp_right_sample (rsp_right_sample),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   // A first copy that is taken is followed by the final copy of the same frame.
   `PFN_ASSERT_NEXT(a_dup_second, clock, reset, rsp_valid && rsp_ready && !rsp_last_of_run, rsp_valid && rsp_last_of_run && $stable(rsp_left_sample) && $stable(rsp_right_sample), "second copy of doubled frame missing or changed")
   // A registered word that cannot move on is still held next cycle.
   `PFN_ASSERT_NEXT(a_word_held, clock, reset, a_valid_ff && !out_free, a_valid_ff && $stable(a_sample_ff), "stalled sample word lost")
   // A frame still waiting for its second copy blocks the next load.
   `PFN_ASSERT_SAME(a_no_overwrite, clock, reset, rsp_valid && !rsp_last_of_run, !a_advance, "result register overwritten before last copy")

endmodule
